// ===== src/iatp_pkg.sv =====
package iatp_pkg;

    localparam int NUM_GROUPS     = 8;
    localparam int GROUP_W        = 16;
    localparam int GIDX_W         = $clog2(NUM_GROUPS);
    localparam int TOKEN_W        = $clog2(NUM_GROUPS + 1);
    localparam int V4_PARTS       = 4;
    localparam int OCTET_LIMIT    = 256;
    localparam int HEX_DIGITS_MAX = 4;
    localparam int DIGIT_SAT      = 7;
    localparam int STATUS_W       = 2;
    localparam int OUT_BITS       = STATUS_W + NUM_GROUPS * GROUP_W;
    localparam int OUT_TDATA_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        CC_BLANK,
        CC_OPEN,
        CC_CLOSE,
        CC_HEX,
        CC_COLON,
        CC_DOT,
        CC_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  hex;
        logic        is_dec;
        logic        last;
    } char_item_t;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_BODY,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        FORM_UNDEC,
        FORM_V4,
        FORM_V6
    } form_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INVALID,
        ST_V4,
        ST_V6
    } status_t;

    typedef logic [NUM_GROUPS-1:0][GROUP_W-1:0] group_vec_t;

    typedef struct packed {
        phase_t             phase;
        form_t              form;
        logic [GROUP_W-1:0] acc;
        logic [2:0]         digits;
        logic [TOKEN_W-1:0] tokens;
        group_vec_t         grp;
        logic [3:0]         gap;
        logic               bracket;
        logic               err;
        logic [8:0]         dec;
        logic               non_dec;
        logic [1:0]         colons;
        status_t            done_status;
    } parse_state_t;

endpackage

// ===== src/ip_address_text_parser_top.sv =====
// Parses IPv4 dotted-decimal or IPv6 colon-hex address text, one character per transaction.
// The slave channel carries the character in s_tdata and marks the final character of each
// string with s_tlast. Leading blanks are skipped and a bracketed IPv6 form is accepted.
// The master channel gives one transaction per string: the status (invalid, IPv4 or IPv6)
// and eight 16-bit groups, with IPv4 octets in the first four groups.
// A character can be accepted in every cycle while the queue has room. Characters are
// classified into a short queue, and the parser takes one from it per cycle, so the sustained
// rate is one character per clock while no final character waits behind an untaken result.
// A final character passes a queue slot register, then the output register, to raise m_tvalid.
// The result sits in an output register; while it waits, the parser keeps consuming the
// characters of the next string and stops only at that string's final character. When the
// queue fills, s_tready falls.
// Reset empties the queue, drops any pending result and returns the parser to the start of
// a string.
module ip_address_text_parser_top
    import iatp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,  // char_code
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata   // status, group_0 .. group_7, zero padding
);

    logic       q_push;
    logic       q_full;
    char_item_t q_push_item;
    logic       q_valid;
    char_item_t q_item;
    logic       q_pop;

    iatp_classify u_classify
    (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_item (q_push_item)
    );

    iatp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_item  (q_item),
        .pop       (q_pop)
    );

    iatp_parse u_parse
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(q_pop && q_item.last))
        else $error("Result appeared without a final character being consumed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_valid)
        else $error("Input stalled while the queue was empty.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_item.last) |-> (!m_tvalid || m_tready))
        else $error("Result register overwritten before it was taken.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[STATUS_W-1:0] == ST_INVALID)
            |-> (m_tdata[OUT_BITS-1:STATUS_W] == '0))
        else $error("Invalid result carries non-zero groups.");
`endif

endmodule

// ===== src/iatp_classify.sv =====
module iatp_classify
    import iatp_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       q_full,
    output logic       q_push,
    output char_item_t q_push_item
);

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] TEN      = 8'd10;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_push_item.cls    = CC_OTHER;
        q_push_item.hex    = '0;
        q_push_item.is_dec = 1'b0;
        q_push_item.last   = s_tlast;
        if (s_tdata inside {[CH_ZERO:CH_NINE]})
        begin
            q_push_item.cls    = CC_HEX;
            q_push_item.hex    = 4'(s_tdata - CH_ZERO);
            q_push_item.is_dec = 1'b1;
        end
        else if (s_tdata inside {[CH_LO_A:CH_LO_F]})
        begin
            q_push_item.cls = CC_HEX;
            q_push_item.hex = 4'(s_tdata - CH_LO_A + TEN);
        end
        else if (s_tdata inside {[CH_UP_A:CH_UP_F]})
        begin
            q_push_item.cls = CC_HEX;
            q_push_item.hex = 4'(s_tdata - CH_UP_A + TEN);
        end
        else if (s_tdata == CH_SPACE || s_tdata == CH_TAB)
        begin
            q_push_item.cls = CC_BLANK;
        end
        else if (s_tdata == CH_OPEN)
        begin
            q_push_item.cls = CC_OPEN;
        end
        else if (s_tdata == CH_CLOSE)
        begin
            q_push_item.cls = CC_CLOSE;
        end
        else if (s_tdata == CH_COLON)
        begin
            q_push_item.cls = CC_COLON;
        end
        else if (s_tdata == CH_DOT)
        begin
            q_push_item.cls = CC_DOT;
        end
    end

endmodule

// ===== src/iatp_queue.sv =====
module iatp_queue
    import iatp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  char_item_t push_item,
    output logic       full,
    output logic       pop_valid,
    output char_item_t pop_item,
    input  logic       pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    char_item_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/iatp_parse.sv =====
module iatp_parse
    import iatp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  char_item_t             q_item,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam parse_state_t STATE_INIT = '{
        phase:       PH_LEAD,
        form:        FORM_UNDEC,
        acc:         '0,
        digits:      '0,
        tokens:      '0,
        grp:         '0,
        gap:         '0,
        bracket:     1'b0,
        err:         1'b0,
        dec:         '0,
        non_dec:     1'b0,
        colons:      '0,
        done_status: ST_INVALID
    };

    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t step_s;
    parse_state_t fin_s;
    parse_state_t src_s;
    status_t      fin_status;
    status_t      res_status;
    group_vec_t   res_groups;
    logic         run_body;
    logic         do_close;
    logic         use_fin;
    logic [11:0]  dec_mac;
    logic [2:0]   digits_inc;
    logic         out_valid_reg;
    logic         out_valid_next;
    status_t      out_status_reg;
    group_vec_t   out_groups_reg;

    function automatic parse_state_t push_group(input parse_state_t s,
                                                input logic [GROUP_W-1:0] v);
        parse_state_t r;
        r = s;
        if (s.tokens >= TOKEN_W'(NUM_GROUPS))
        begin
            r.err = 1'b1;
        end
        else
        begin
            if (s.gap != '0)
            begin
                for (int k = 0; k < NUM_GROUPS - 1; k++)
                begin
                    if (4'(k) + 4'd1 >= s.gap)
                    begin
                        r.grp[k] = s.grp[k + 1];
                    end
                end
                r.grp[NUM_GROUPS - 1] = v;
            end
            else
            begin
                r.grp[s.tokens[GIDX_W-1:0]] = v;
            end
            r.tokens = s.tokens + 1'b1;
        end
        return r;
    endfunction

    assign q_pop    = q_valid && (!q_item.last || !out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, out_groups_reg, out_status_reg};

    always_comb
    begin
        dec_mac    = ({3'b000, state_reg.dec} << 3) + ({3'b000, state_reg.dec} << 1)
                     + {8'h00, q_item.hex};
        digits_inc = (state_reg.digits < 3'(DIGIT_SAT)) ? state_reg.digits + 3'd1
                                                        : state_reg.digits;
    end

    always_comb
    begin
        step_s   = state_reg;
        run_body = 1'b0;
        do_close = 1'b0;
        case (state_reg.phase)
            PH_LEAD:
            begin
                if (q_item.cls == CC_OPEN)
                begin
                    step_s.bracket = 1'b1;
                    step_s.phase   = PH_BODY;
                end
                else if (q_item.cls != CC_BLANK)
                begin
                    step_s.phase = PH_BODY;
                    run_body     = 1'b1;
                end
            end
            PH_BODY: run_body = 1'b1;
            default: run_body = 1'b0;
        endcase

        if (run_body && !state_reg.err)
        begin
            case (q_item.cls)
                CC_CLOSE:
                begin
                    if (state_reg.bracket)
                    begin
                        do_close = 1'b1;
                    end
                    else
                    begin
                        step_s.err = 1'b1;
                    end
                end
                CC_HEX:
                begin
                    if (state_reg.form == FORM_V4)
                    begin
                        if (!q_item.is_dec || dec_mac >= 12'(OCTET_LIMIT))
                        begin
                            step_s.err = 1'b1;
                        end
                        else
                        begin
                            step_s.dec    = dec_mac[8:0];
                            step_s.digits = digits_inc;
                        end
                    end
                    else if (state_reg.colons == 2'd1 && state_reg.tokens == '0
                             && state_reg.gap == '0)
                    begin
                        step_s.err = 1'b1;
                    end
                    else
                    begin
                        step_s.colons = 2'd0;
                        step_s.digits = digits_inc;
                        if (state_reg.form == FORM_V6)
                        begin
                            if (digits_inc > 3'(HEX_DIGITS_MAX))
                            begin
                                step_s.err = 1'b1;
                            end
                            else
                            begin
                                step_s.acc = {state_reg.acc[GROUP_W-5:0], q_item.hex};
                            end
                        end
                        else
                        begin
                            if (digits_inc <= 3'(HEX_DIGITS_MAX))
                            begin
                                step_s.acc = {state_reg.acc[GROUP_W-5:0], q_item.hex};
                            end
                            if (q_item.is_dec)
                            begin
                                step_s.dec = (dec_mac >= 12'(OCTET_LIMIT)) ? 9'(OCTET_LIMIT)
                                                                           : dec_mac[8:0];
                            end
                            else
                            begin
                                step_s.non_dec = 1'b1;
                            end
                        end
                    end
                end
                CC_COLON:
                begin
                    if (state_reg.form == FORM_V4)
                    begin
                        step_s.err = 1'b1;
                    end
                    else if (state_reg.form == FORM_UNDEC
                             && state_reg.digits > 3'(HEX_DIGITS_MAX))
                    begin
                        step_s.err = 1'b1;
                    end
                    else
                    begin
                        step_s.form = FORM_V6;
                        if (state_reg.digits != '0)
                        begin
                            step_s        = push_group(step_s, state_reg.acc);
                            step_s.acc    = '0;
                            step_s.digits = '0;
                            step_s.colons = 2'd1;
                        end
                        else if (state_reg.colons == 2'd0)
                        begin
                            step_s.colons = 2'd1;
                        end
                        else if (state_reg.colons == 2'd1)
                        begin
                            if (state_reg.gap != '0)
                            begin
                                step_s.err = 1'b1;
                            end
                            else
                            begin
                                step_s.gap    = 4'(state_reg.tokens) + 4'd1;
                                step_s.colons = 2'd2;
                            end
                        end
                        else
                        begin
                            step_s.err = 1'b1;
                        end
                    end
                end
                CC_DOT:
                begin
                    if (state_reg.form == FORM_V6)
                    begin
                        step_s.err = 1'b1;
                    end
                    else if (state_reg.form == FORM_UNDEC && (state_reg.bracket
                             || state_reg.non_dec || state_reg.dec >= 9'(OCTET_LIMIT)))
                    begin
                        step_s.err = 1'b1;
                    end
                    else if (state_reg.digits == '0
                             || state_reg.tokens >= TOKEN_W'(V4_PARTS - 1))
                    begin
                        step_s.err = 1'b1;
                    end
                    else
                    begin
                        step_s.form   = FORM_V4;
                        step_s.grp[state_reg.tokens[GIDX_W-1:0]] =
                            {{(GROUP_W - 9){1'b0}}, state_reg.dec};
                        step_s.tokens = state_reg.tokens + 1'b1;
                        step_s.dec    = '0;
                        step_s.digits = '0;
                        step_s.acc    = '0;
                    end
                end
                default: step_s.err = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        fin_s      = step_s;
        fin_status = ST_INVALID;
        if (!step_s.err && step_s.form == FORM_V4)
        begin
            if (step_s.digits != '0 && step_s.tokens == TOKEN_W'(V4_PARTS - 1))
            begin
                fin_status = ST_V4;
            end
        end
        else if (!step_s.err && step_s.form == FORM_V6)
        begin
            if (step_s.digits != '0)
            begin
                fin_s = push_group(step_s, step_s.acc);
            end
            else if (step_s.colons == 2'd1)
            begin
                fin_s.err = 1'b1;
            end
            if (!fin_s.err)
            begin
                if (fin_s.gap != '0)
                begin
                    if (fin_s.tokens < TOKEN_W'(NUM_GROUPS))
                    begin
                        fin_status = ST_V6;
                    end
                end
                else if (fin_s.tokens == TOKEN_W'(NUM_GROUPS))
                begin
                    fin_status = ST_V6;
                end
            end
        end
    end

    always_comb
    begin
        use_fin = do_close || (step_s.phase == PH_BODY && !step_s.bracket);
        src_s   = use_fin ? fin_s : state_reg;
        if (use_fin)
        begin
            res_status = fin_status;
        end
        else if (step_s.phase == PH_DONE)
        begin
            res_status = state_reg.done_status;
        end
        else
        begin
            res_status = ST_INVALID;
        end

        for (int j = 0; j < NUM_GROUPS; j++)
        begin
            res_groups[j] = '0;
            case (res_status)
                ST_V4:
                begin
                    if (j < V4_PARTS - 1)
                    begin
                        res_groups[j] = src_s.grp[j];
                    end
                    else if (j == V4_PARTS - 1)
                    begin
                        res_groups[j] = {{(GROUP_W - 9){1'b0}}, src_s.dec};
                    end
                end
                ST_V6:
                begin
                    if (src_s.gap == '0)
                    begin
                        res_groups[j] = src_s.grp[j];
                    end
                    else if (5'(j) + 5'd1 < {1'b0, src_s.gap}
                             || {1'b0, src_s.tokens} + 5'(j) + 5'd1
                                >= 5'(NUM_GROUPS) + {1'b0, src_s.gap})
                    begin
                        res_groups[j] = src_s.grp[j];
                    end
                end
                default: res_groups[j] = '0;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (q_pop)
        begin
            if (q_item.last)
            begin
                state_next     = STATE_INIT;
                state_next.grp = state_reg.grp;
                out_valid_next = 1'b1;
            end
            else if (do_close)
            begin
                state_next             = fin_s;
                state_next.phase       = PH_DONE;
                state_next.done_status = fin_status;
            end
            else
            begin
                state_next = step_s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.last)
        begin
            out_status_reg <= res_status;
            out_groups_reg <= res_groups;
        end
    end

endmodule
